// ===== rtl/core/c8ex_pkg.sv =====
// Package for the 8-bit execute block: item types, function codes,
// flag constants and small helper functions. Depends on nothing.
package c8ex_pkg;

    localparam int unsigned STACK_DEPTH = 256;

    localparam logic [7:0]  FLAG_N      = 8'h80;
    localparam logic [7:0]  FLAG_Z      = 8'h02;
    localparam logic [7:0]  FLAG_C      = 8'h01;
    localparam logic [7:0]  PHP_SET     = 8'h30;
    localparam logic [7:0]  PLP_MASK    = 8'hCF;
    localparam logic [7:0]  SP_RESET    = 8'hFD;
    localparam logic [15:0] LOW_BYTE    = 16'h00FF;

    typedef enum logic [3:0] {
        FN_JMP     = 4'd0,
        FN_JSR     = 4'd1,
        FN_LDA     = 4'd2,
        FN_LDX     = 4'd3,
        FN_LDY     = 4'd4,
        FN_LSR_A   = 4'd5,
        FN_LSR_MEM = 4'd6,
        FN_NOP     = 4'd7,
        FN_ORA     = 4'd8,
        FN_PHA     = 4'd9,
        FN_PHP     = 4'd10,
        FN_PLA     = 4'd11,
        FN_PLP     = 4'd12
    } t_func;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_JSR_LO,
        ST_POP
    } t_state;

    typedef struct packed {
        logic [3:0]  func;
        logic [7:0]  operand_byte;
        logic [15:0] effective_address;
        logic [15:0] pc_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pc_out;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  status_out;
        logic [7:0]  sp_out;
        logic        mem_write_valid;
        logic [15:0] mem_write_addr;
        logic [7:0]  mem_write_data;
    } t_out_item;

    // One access to the stack RAM; the slot is already reduced below the depth.
    typedef struct packed {
        logic       en;
        logic       we;
        logic [7:0] slot;
        logic [7:0] wdata;
    } t_stk_req;

    // Update N and Z from a result byte.
    function automatic logic [7:0] set_nz(input logic [7:0] st, input logic [7:0] v);
        logic [7:0] s;
        s = st & ~(FLAG_N | FLAG_Z);
        if (v == 8'd0) s = s | FLAG_Z;
        if (v[7]) s = s | FLAG_N;
        return s;
    endfunction

    // Status after a right shift of v: C from old bit 0, Z from result, N cleared.
    function automatic logic [7:0] lsr_status(input logic [7:0] st, input logic [7:0] v);
        logic [7:0] s;
        s = st & ~(FLAG_N | FLAG_Z | FLAG_C);
        if (v[0]) s = s | FLAG_C;
        if (v[7:1] == 7'd0) s = s | FLAG_Z;
        return s;
    endfunction

    // Stack pointer reduced modulo the RAM depth by restoring subtraction.
    function automatic logic [7:0] stk_slot(input logic [7:0] sp, input int unsigned depth);
        logic [15:0] rem;
        logic [15:0] m;
        rem = {8'd0, sp};
        for (int k = 7; k >= 0; k--) begin
            m = 16'(depth) << k;
            if (rem >= m) rem = rem - m;
        end
        return rem[7:0];
    endfunction

endpackage

// ===== rtl/core/c8ex_in_if.sv =====
// Input channel of the execute block: valid/ready handshake and one
// instruction item. Depends on c8ex_pkg.
interface c8ex_in_if;
    logic                valid;
    logic                ready;
    c8ex_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/c8ex_out_if.sv =====
// Result channel of the execute block: valid/ready handshake and one
// result item. Depends on c8ex_pkg.
interface c8ex_out_if;
    logic                valid;
    logic                ready;
    c8ex_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/c8ex_stack_ram.sv =====
// Single-port stack RAM with registered read data.
// Depends on c8ex_pkg for the request type.
module c8ex_stack_ram #(
    parameter int unsigned STACK_DEPTH = c8ex_pkg::STACK_DEPTH
) (
    input  logic                i_clk,
    input  c8ex_pkg::t_stk_req  i_req,
    output logic [7:0]          o_rdata
);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [7:0] mem [STACK_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                mem[i_req.slot[AW-1:0]] <= i_req.wdata;
            end else begin
                r_rdata <= mem[i_req.slot[AW-1:0]];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/cpu8_execute_load_shift_stack_ops.sv =====
// Top level of the 8-bit execute block for the load, shift and stack subset.
// Depends on c8ex_pkg, c8ex_in_if, c8ex_out_if and c8ex_stack_ram.
//
// Usage: the addressing stage hands one instruction item per handshake on
// i_item (function code, operand byte, effective address, PC after operand
// fetch). The block returns exactly one result item per instruction on
// o_result: new PC, A, X, Y, status, stack pointer and the write-back request
// of a memory LSR. Accumulator, index, status and stack pointer live in flops;
// the stack page lives in a single-port RAM with registered read data.
// For most instructions the result is registered at the accept edge, and the
// next item can be taken as soon as the result register is free. JSR needs
// a second state, ST_JSR_LO, because its two return-address bytes need two
// writes through the single RAM port. PLA and PLP pass through ST_POP, because
// the popped byte arrives in the cycle after the read is issued; the result is
// registered once that byte is there.
// Reset (synchronous, active low) clears A, X, Y and status, sets the stack
// pointer to 0xFD and empties the result register. The RAM has no reset and
// needs no clearing pass. When the receiver holds o_result.ready low, the
// finished item waits in the result register and i_item.ready drops, so
// nothing is lost; the next item is taken in the same cycle the waiting
// result is taken.
module cpu8_execute_load_shift_stack_ops #(
    parameter int unsigned STACK_DEPTH = c8ex_pkg::STACK_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    c8ex_in_if.sink      i_item,
    c8ex_out_if.source   o_result
);

    // Architectural registers.
    logic [7:0]           r_acc, n_acc;
    logic [7:0]           r_x, n_x;
    logic [7:0]           r_y, n_y;
    logic [7:0]           r_status, n_status;
    logic [7:0]           r_sp, n_sp;

    // Sequencer and the values that carry over into ST_JSR_LO and ST_POP.
    c8ex_pkg::t_state     r_state, n_state;
    logic [7:0]           r_jsr_lo, n_jsr_lo;
    logic                 r_pop_plp, n_pop_plp;
    logic [15:0]          r_pop_pc, n_pop_pc;

    // Result register.
    c8ex_pkg::t_out_item  r_out, n_out;
    logic                 r_out_valid, n_out_valid;

    c8ex_pkg::t_stk_req   stk_req;
    logic [7:0]           stk_rdata;
    logic [7:0]           stk_sp;
    logic                 accept;
    logic                 out_free;
    logic                 load_out;
    logic [15:0]          pc_next;
    logic [15:0]          ret_addr;
    logic [7:0]           lsr_mem;

    // The result register is free when empty or being taken this cycle.
    assign out_free     = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == c8ex_pkg::ST_RUN) && out_free;
    assign accept       = i_item.valid && i_item.ready;

    assign pc_next  = i_item.data.pc_in + 16'd1;
    assign ret_addr = i_item.data.pc_in - 16'd1;
    assign lsr_mem  = {1'b0, i_item.data.operand_byte[7:1]};

    c8ex_stack_ram #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_req   (stk_req),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= c8ex_pkg::ST_RUN;
            r_acc       <= 8'd0;
            r_x         <= 8'd0;
            r_y         <= 8'd0;
            r_status    <= 8'd0;
            r_sp        <= c8ex_pkg::SP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_x         <= n_x;
            r_y         <= n_y;
            r_status    <= n_status;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_jsr_lo  <= n_jsr_lo;
        r_pop_plp <= n_pop_plp;
        r_pop_pc  <= n_pop_pc;
        r_out     <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_x       = r_x;
        n_y       = r_y;
        n_status  = r_status;
        n_sp      = r_sp;
        n_jsr_lo  = r_jsr_lo;
        n_pop_plp = r_pop_plp;
        n_pop_pc  = r_pop_pc;
        n_out     = r_out;
        load_out  = 1'b0;
        stk_sp    = r_sp;

        stk_req.en    = 1'b0;
        stk_req.we    = 1'b0;
        stk_req.wdata = 8'd0;

        n_out.pc_out          = r_out.pc_out;
        n_out.mem_write_valid = r_out.mem_write_valid;
        n_out.mem_write_addr  = r_out.mem_write_addr;
        n_out.mem_write_data  = r_out.mem_write_data;

        case (r_state)
            c8ex_pkg::ST_RUN: begin
                if (accept) begin
                    load_out              = 1'b1;
                    n_out.pc_out          = i_item.data.pc_in;
                    n_out.mem_write_valid = 1'b0;
                    n_out.mem_write_addr  = 16'd0;
                    n_out.mem_write_data  = 8'd0;
                    case (i_item.data.func)
                        c8ex_pkg::FN_JMP: begin
                            n_out.pc_out = i_item.data.effective_address;
                        end
                        c8ex_pkg::FN_JSR: begin
                            // High byte now, low byte in the next cycle.
                            stk_req.en    = 1'b1;
                            stk_req.we    = 1'b1;
                            stk_req.wdata = ret_addr[15:8];
                            n_jsr_lo      = 8'(ret_addr & c8ex_pkg::LOW_BYTE);
                            n_sp          = r_sp - 8'd2;
                            n_state       = c8ex_pkg::ST_JSR_LO;
                            n_out.pc_out  = i_item.data.effective_address;
                        end
                        c8ex_pkg::FN_LDA: begin
                            n_acc    = i_item.data.operand_byte;
                            n_status = c8ex_pkg::set_nz(r_status, i_item.data.operand_byte);
                        end
                        c8ex_pkg::FN_LDX: begin
                            n_x      = i_item.data.operand_byte;
                            n_status = c8ex_pkg::set_nz(r_status, i_item.data.operand_byte);
                        end
                        c8ex_pkg::FN_LDY: begin
                            n_y      = i_item.data.operand_byte;
                            n_status = c8ex_pkg::set_nz(r_status, i_item.data.operand_byte);
                        end
                        c8ex_pkg::FN_LSR_A: begin
                            n_acc        = {1'b0, r_acc[7:1]};
                            n_status     = c8ex_pkg::lsr_status(r_status, r_acc);
                            n_out.pc_out = pc_next;
                        end
                        c8ex_pkg::FN_LSR_MEM: begin
                            n_status              = c8ex_pkg::lsr_status(r_status,
                                                        i_item.data.operand_byte);
                            n_out.mem_write_valid = 1'b1;
                            n_out.mem_write_addr  = i_item.data.effective_address;
                            n_out.mem_write_data  = lsr_mem;
                        end
                        c8ex_pkg::FN_NOP: begin
                            n_out.pc_out = pc_next;
                        end
                        c8ex_pkg::FN_ORA: begin
                            n_acc    = r_acc | i_item.data.operand_byte;
                            n_status = c8ex_pkg::set_nz(r_status,
                                           r_acc | i_item.data.operand_byte);
                        end
                        c8ex_pkg::FN_PHA: begin
                            stk_req.en    = 1'b1;
                            stk_req.we    = 1'b1;
                            stk_req.wdata = r_acc;
                            n_sp          = r_sp - 8'd1;
                            n_out.pc_out  = pc_next;
                        end
                        c8ex_pkg::FN_PHP: begin
                            stk_req.en    = 1'b1;
                            stk_req.we    = 1'b1;
                            stk_req.wdata = r_status | c8ex_pkg::PHP_SET;
                            n_sp          = r_sp - 8'd1;
                            n_out.pc_out  = pc_next;
                        end
                        c8ex_pkg::FN_PLA, c8ex_pkg::FN_PLP: begin
                            // Issue the read now; registers and result follow
                            // when the byte comes back.
                            stk_sp    = r_sp + 8'd1;
                            stk_req.en = 1'b1;
                            n_sp      = r_sp + 8'd1;
                            n_pop_plp = (i_item.data.func == c8ex_pkg::FN_PLP);
                            n_pop_pc  = pc_next;
                            n_state   = c8ex_pkg::ST_POP;
                            load_out  = 1'b0;
                        end
                        default: begin
                            // Unused codes leave the registers unchanged; a result item is still returned.
                        end
                    endcase
                end
            end
            c8ex_pkg::ST_JSR_LO: begin
                // The stack pointer has already dropped by two; the low byte
                // goes one above it.
                stk_sp        = r_sp + 8'd1;
                stk_req.en    = 1'b1;
                stk_req.we    = 1'b1;
                stk_req.wdata = r_jsr_lo;
                n_state       = c8ex_pkg::ST_RUN;
            end
            c8ex_pkg::ST_POP: begin
                // The result register was left empty at the pop's accept.
                load_out              = 1'b1;
                n_out.pc_out          = r_pop_pc;
                n_out.mem_write_valid = 1'b0;
                n_out.mem_write_addr  = 16'd0;
                n_out.mem_write_data  = 8'd0;
                if (r_pop_plp) begin
                    n_status = stk_rdata & c8ex_pkg::PLP_MASK;
                end else begin
                    n_acc    = stk_rdata;
                    n_status = c8ex_pkg::set_nz(r_status, stk_rdata);
                end
                n_state = c8ex_pkg::ST_RUN;
            end
            default: begin
                n_state = c8ex_pkg::ST_RUN;
            end
        endcase

        stk_req.slot = c8ex_pkg::stk_slot(stk_sp, STACK_DEPTH);

        n_out.acc_out    = load_out ? n_acc    : r_out.acc_out;
        n_out.x_out      = load_out ? n_x      : r_out.x_out;
        n_out.y_out      = load_out ? n_y      : r_out.y_out;
        n_out.status_out = load_out ? n_status : r_out.status_out;
        n_out.sp_out     = load_out ? n_sp     : r_out.sp_out;

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule
